// ----- design/stt_pkg.sv -----
// Shared types, token kinds and character constants for the source text tokenizer.
package stt_pkg;

  // Token kinds as they appear on the result channel
  localparam logic [3:0] KIND_FUN    = 4'd0;
  localparam logic [3:0] KIND_BOOL   = 4'd1;
  localparam logic [3:0] KIND_INT    = 4'd2;
  localparam logic [3:0] KIND_STRING = 4'd3;
  localparam logic [3:0] KIND_IDENT  = 4'd4;
  localparam logic [3:0] KIND_LBRACE = 4'd5;
  localparam logic [3:0] KIND_RBRACE = 4'd6;
  localparam logic [3:0] KIND_LPAREN = 4'd7;
  localparam logic [3:0] KIND_RPAREN = 4'd8;
  localparam logic [3:0] KIND_SEMI   = 4'd9;
  localparam logic [3:0] KIND_COMMA  = 4'd10;

  // Largest integer value before saturation
  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword identifiers
  localparam int         KW_NUM   = 3;
  localparam logic [1:0] KW_FUN   = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  // Classification of one source byte
  typedef struct packed {
    logic       is_space;
    logic       is_nul;
    logic       is_digit;
    logic       is_alpha;
    logic       is_quote;
    logic       is_mark;
    logic [3:0] mark_kind;
    logic [3:0] digit;
  } char_class_t;

  // Length of a keyword
  function automatic logic [2:0] kw_len(input logic [1:0] kw);
    logic [2:0] len;
    case (kw)
      KW_FUN:   len = 3'd3;
      KW_TRUE:  len = 3'd4;
      KW_FALSE: len = 3'd5;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  // Character of a keyword at one position
  function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (kw)
      KW_FUN: begin
        case (pos)
          3'd0:    ch = 8'h66; // f
          3'd1:    ch = 8'h75; // u
          3'd2:    ch = 8'h6E; // n
          default: ch = 8'h00;
        endcase
      end
      KW_TRUE: begin
        case (pos)
          3'd0:    ch = 8'h74; // t
          3'd1:    ch = 8'h72; // r
          3'd2:    ch = 8'h75; // u
          3'd3:    ch = 8'h65; // e
          default: ch = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0:    ch = 8'h66; // f
          3'd1:    ch = 8'h61; // a
          3'd2:    ch = 8'h6C; // l
          3'd3:    ch = 8'h73; // s
          3'd4:    ch = 8'h65; // e
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/stt_char_class.sv -----
// Byte classifier: sorts one source character into digit, letter, quote, NUL, mark and separator classes.
module stt_char_class (
  input  logic [7:0]          ch,
  output stt_pkg::char_class_t cls
);
  import stt_pkg::*;

  logic [7:0] diff;

  assign diff = ch - CH_ZERO;

  // Classify the byte
  always_comb begin
    cls           = '0;
    cls.is_space  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
    cls.is_nul    = (ch == CH_NUL);
    cls.is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    cls.is_alpha  = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ||
                    ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
    cls.is_quote  = (ch == CH_QUOTE);
    cls.digit     = diff[3:0];
    cls.is_mark   = 1'b1;
    unique case (ch)
      CH_LBRACE: cls.mark_kind = KIND_LBRACE;
      CH_RBRACE: cls.mark_kind = KIND_RBRACE;
      CH_LPAREN: cls.mark_kind = KIND_LPAREN;
      CH_RPAREN: cls.mark_kind = KIND_RPAREN;
      CH_SEMI:   cls.mark_kind = KIND_SEMI;
      CH_COMMA:  cls.mark_kind = KIND_COMMA;
      default: begin
        cls.is_mark   = 1'b0;
        cls.mark_kind = KIND_FUN;
      end
    endcase
  end

endmodule

// ----- design/source_text_tokenizer_core.sv -----
// Top level of the source text tokenizer: scan sequencer, text memory and result register.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | in_byte, in_end_of_data
//   out_    | output    | out_valid/out_ready | token_kind .. run_last, one word per result
//
// A byte passes S_STEP alone when it extends a token or follows a NUL, S_STEP and S_START
// when it arrives between tokens, and S_STEP, S_FLUSH and S_START or S_END when it ends
// a token; each text character is read in S_TXT_RD and loaded in S_TXT_WR, as the text
// memory read is registered ahead of the result register. End of data adds its own flush.
// Reset (rst_n low, synchronous) returns the scanner to idle; the text memory is not cleared.
// Stalls on out_ready hold the sequencer; in_ready is high only between bytes.
module source_text_tokenizer_core #(
  parameter int MAX_TEXT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [30:0] out_int_value,
  output logic        out_bool_value,
  output logic        out_text_valid,
  output logic [7:0]  out_text_char,
  output logic [4:0]  out_char_index,
  output logic        out_text_end,
  output logic        out_overflowed,
  output logic        out_run_last
);
  import stt_pkg::*;

  localparam int AW    = $clog2(MAX_TEXT);
  localparam int LEN_W = $clog2(MAX_TEXT + 1);

  // Scan modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_NUMBER = 3'd1;
  localparam logic [2:0] MODE_STRING = 3'd2;
  localparam logic [2:0] MODE_WORD   = 3'd3;
  localparam logic [2:0] MODE_DONE   = 3'd4;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_END    = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_TXT_RD = 3'd5;
  localparam logic [2:0] S_TXT_WR = 3'd6;

  // Sequencer and token state
  logic [2:0]        state_r, state_nxt;
  logic [2:0]        resume_r, resume_nxt;
  logic [2:0]        post_mode_r, post_mode_nxt;
  logic              more_r, more_nxt;
  logic [7:0]        c_r, c_nxt;
  logic              last_r, last_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [30:0]       acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [KW_NUM-1:0] kwf_r, kwf_nxt;
  logic [3:0]        emit_kind_r, emit_kind_nxt;
  logic [LEN_W-1:0]  emit_len_r, emit_len_nxt;
  logic              emit_ovf_r, emit_ovf_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;

  // Result register
  logic        out_valid_r;
  logic [3:0]  out_kind_r, out_kind_nxt;
  logic [30:0] out_int_r, out_int_nxt;
  logic        out_bool_r, out_bool_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic [4:0]  out_idx_r, out_idx_nxt;
  logic        out_tend_r, out_tend_nxt;
  logic        out_ovf_r, out_ovf_nxt;
  logic        out_rlast_r, out_rlast_nxt;
  logic        out_load;
  logic        slot_free;

  // Text memory
  logic [7:0]    text_mem [MAX_TEXT];
  logic [7:0]    rd_q;
  logic          rd_en;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  // Helpers
  char_class_t       cls;
  logic              store_ok;
  logic [KW_NUM-1:0] kw_hit;
  logic              any_kw;
  logic [34:0]       acc_ext;
  logic [34:0]       acc_mul;
  logic              txt_end;
  logic              single_item;
  logic              text_stream;
  logic [3:0]        text_kind;
  logic              start_more;

  stt_char_class u_class (
    .ch  (c_r),
    .cls (cls)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign store_ok  = (len_r < LEN_W'(MAX_TEXT));
  assign acc_ext   = {4'b0000, acc_r};
  assign acc_mul   = (acc_ext << 3) + (acc_ext << 1) + {31'd0, cls.digit};
  assign txt_end   = ((LEN_W'(idx_r) + LEN_W'(1)) == emit_len_r);
  assign text_kind = (mode_r == MODE_STRING) ? KIND_STRING : KIND_IDENT;
  // A flush at a token's ending character is followed by a mark or a new token flushed at end
  assign start_more = cls.is_mark ||
                      (last_r && (cls.is_digit || cls.is_quote || cls.is_alpha));

  // Match the pending word against the keywords
  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      kw_hit[k] = !ovf_r && kwf_r[k] && (len_r == LEN_W'(kw_len(2'(k))));
    end
    any_kw = (mode_r == MODE_WORD) && (|kw_hit);
  end

  assign single_item = (mode_r == MODE_NUMBER) || any_kw ||
                       (((mode_r == MODE_WORD) || (mode_r == MODE_STRING)) &&
                        (len_r == '0));
  assign text_stream = (((mode_r == MODE_WORD) && !any_kw) || (mode_r == MODE_STRING)) &&
                       (len_r != '0);

  // Sequence one byte through flush, start and end-of-data steps
  always_comb begin
    state_nxt     = state_r;
    resume_nxt    = resume_r;
    post_mode_nxt = post_mode_r;
    more_nxt      = more_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    kwf_nxt       = kwf_r;
    emit_kind_nxt = emit_kind_r;
    emit_len_nxt  = emit_len_r;
    emit_ovf_nxt  = emit_ovf_r;
    idx_nxt       = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = len_r[AW-1:0];
    rd_en         = 1'b0;
    out_load       = 1'b0;
    out_kind_nxt   = KIND_FUN;
    out_int_nxt    = '0;
    out_bool_nxt   = 1'b0;
    out_tvalid_nxt = 1'b0;
    out_char_nxt   = '0;
    out_idx_nxt    = '0;
    out_tend_nxt   = 1'b1;
    out_ovf_nxt    = 1'b0;
    out_rlast_nxt  = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          c_nxt     = in_byte;
          last_nxt  = in_end_of_data;
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        unique case (mode_r)
          MODE_NUMBER: begin
            if (cls.is_digit) begin
              // accumulate with saturation
              if (acc_mul > {4'b0000, INT_MAX31}) begin
                acc_nxt = INT_MAX31;
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = acc_mul[30:0];
              end
              state_nxt = last_r ? S_END : S_IDLE;
            end else begin
              post_mode_nxt = MODE_IDLE;
              more_nxt      = start_more;
              resume_nxt    = S_START;
              state_nxt     = S_FLUSH;
            end
          end
          MODE_WORD, MODE_STRING: begin
            if ((mode_r == MODE_WORD) && !cls.is_alpha) begin
              post_mode_nxt = MODE_IDLE;
              more_nxt      = start_more;
              resume_nxt    = S_START;
              state_nxt     = S_FLUSH;
            end else if ((mode_r == MODE_STRING) && (cls.is_quote || cls.is_nul)) begin
              post_mode_nxt = cls.is_nul ? MODE_DONE : MODE_IDLE;
              more_nxt      = 1'b0;
              resume_nxt    = S_END;
              state_nxt     = S_FLUSH;
            end else begin
              // append the character, or mark truncation
              if (store_ok) begin
                mem_we  = 1'b1;
                len_nxt = len_r + LEN_W'(1);
                for (int k = 0; k < KW_NUM; k++) begin
                  kwf_nxt[k] = kwf_r[k] &&
                               ((len_r >= LEN_W'(kw_len(2'(k)))) ||
                                (c_r == kw_char(2'(k), len_r[2:0])));
                end
              end else begin
                ovf_nxt = 1'b1;
              end
              state_nxt = last_r ? S_END : S_IDLE;
            end
          end
          MODE_DONE: begin
            state_nxt = last_r ? S_END : S_IDLE;
          end
          default: begin
            mode_nxt  = MODE_IDLE;
            state_nxt = S_START;
          end
        endcase
      end

      S_START: begin
        state_nxt = last_r ? S_END : S_IDLE;
        if (cls.is_nul) begin
          mode_nxt = MODE_DONE;
        end else if (cls.is_digit) begin
          mode_nxt = MODE_NUMBER;
          acc_nxt  = {27'd0, cls.digit};
          ovf_nxt  = 1'b0;
        end else if (cls.is_quote) begin
          mode_nxt = MODE_STRING;
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
        end else if (cls.is_alpha) begin
          // first letter goes to entry zero
          mode_nxt  = MODE_WORD;
          ovf_nxt   = 1'b0;
          mem_we    = 1'b1;
          mem_waddr = '0;
          len_nxt   = LEN_W'(1);
          for (int k = 0; k < KW_NUM; k++) begin
            kwf_nxt[k] = (c_r == kw_char(2'(k), 3'd0));
          end
        end else if (cls.is_mark) begin
          // hold until the result register frees up
          if (slot_free) begin
            out_load     = 1'b1;
            out_kind_nxt = cls.mark_kind;
          end else begin
            state_nxt = S_START;
          end
        end
      end

      S_END: begin
        if (last_r) begin
          post_mode_nxt = MODE_IDLE;
          more_nxt      = 1'b0;
          resume_nxt    = S_IDLE;
          state_nxt     = S_FLUSH;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_FLUSH: begin
        if (!single_item || slot_free) begin
          if (single_item) begin
            out_load      = 1'b1;
            out_rlast_nxt = !more_r;
            if (mode_r == MODE_NUMBER) begin
              out_kind_nxt = KIND_INT;
              out_int_nxt  = acc_r;
              out_ovf_nxt  = ovf_r;
            end else if (any_kw) begin
              out_kind_nxt = kw_hit[KW_FUN] ? KIND_FUN : KIND_BOOL;
              out_bool_nxt = kw_hit[KW_TRUE];
            end else begin
              out_kind_nxt = text_kind;
              out_ovf_nxt  = ovf_r;
            end
          end
          if (text_stream) begin
            emit_kind_nxt = text_kind;
            emit_len_nxt  = len_r;
            emit_ovf_nxt  = ovf_r;
            idx_nxt       = '0;
            state_nxt     = S_TXT_RD;
          end else begin
            state_nxt = resume_r;
          end
          // clear the pending token
          mode_nxt = post_mode_r;
          len_nxt  = '0;
          acc_nxt  = '0;
          ovf_nxt  = 1'b0;
        end
      end

      S_TXT_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_TXT_WR;
      end

      S_TXT_WR: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_kind_nxt   = emit_kind_r;
          out_tvalid_nxt = 1'b1;
          out_char_nxt   = rd_q;
          out_idx_nxt    = 5'(idx_r);
          out_tend_nxt   = txt_end;
          out_ovf_nxt    = emit_ovf_r;
          out_rlast_nxt  = txt_end && !more_r;
          if (txt_end) begin
            state_nxt = resume_r;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_TXT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      resume_r    <= S_IDLE;
      post_mode_r <= MODE_IDLE;
      more_r      <= 1'b0;
      mode_r      <= MODE_IDLE;
      len_r       <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resume_r    <= resume_nxt;
      post_mode_r <= post_mode_nxt;
      more_r      <= more_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    c_r         <= c_nxt;
    last_r      <= last_nxt;
    kwf_r       <= kwf_nxt;
    emit_kind_r <= emit_kind_nxt;
    emit_len_r  <= emit_len_nxt;
    emit_ovf_r  <= emit_ovf_nxt;
    idx_r       <= idx_nxt;
    if (out_load) begin
      out_kind_r   <= out_kind_nxt;
      out_int_r    <= out_int_nxt;
      out_bool_r   <= out_bool_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_char_r   <= out_char_nxt;
      out_idx_r    <= out_idx_nxt;
      out_tend_r   <= out_tend_nxt;
      out_ovf_r    <= out_ovf_nxt;
      out_rlast_r  <= out_rlast_nxt;
    end
  end

  // Text memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= c_r;
    end
    if (rd_en) begin
      rd_q <= text_mem[idx_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_token_kind = out_kind_r;
  assign out_int_value  = out_int_r;
  assign out_bool_value = out_bool_r;
  assign out_text_valid = out_tvalid_r;
  assign out_text_char  = out_char_r;
  assign out_char_index = out_idx_r;
  assign out_text_end   = out_tend_r;
  assign out_overflowed = out_ovf_r;
  assign out_run_last   = out_rlast_r;

endmodule

// ----- design/stt_checker.sv -----
// Port-level checker for the source text tokenizer and its bind to the top level.
module stt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_byte,
  input logic        in_end_of_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_kind,
  input logic [30:0] out_int_value,
  input logic        out_bool_value,
  input logic        out_text_valid,
  input logic [7:0]  out_text_char,
  input logic [4:0]  out_char_index,
  input logic        out_text_end,
  input logic        out_overflowed,
  input logic        out_run_last
);
  import stt_pkg::*;

  // A waiting source word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_end_of_data))
    else $error("source word changed while waiting");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
      $stable(out_int_value) && $stable(out_bool_value) && $stable(out_text_valid) &&
      $stable(out_text_char) && $stable(out_char_index) && $stable(out_text_end) &&
      $stable(out_overflowed) && $stable(out_run_last))
    else $error("result word changed while stalled");

  // No new byte is taken while a word of the same run is still to follow
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("input ready in the middle of a run");

  // Empty text carries no character or position
  a_empty_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_text_valid |-> (out_text_char == 8'd0) && (out_char_index == 5'd0))
    else $error("character shown without text");

  // Only integer words carry a value, only bool words a truth value
  a_value_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_token_kind == KIND_INT) || (out_int_value == 31'd0)) &&
                  ((out_token_kind == KIND_BOOL) || !out_bool_value))
    else $error("value on a word of the wrong kind");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_byte        (in_byte),
  .in_end_of_data (in_end_of_data),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_token_kind (out_token_kind),
  .out_int_value  (out_int_value),
  .out_bool_value (out_bool_value),
  .out_text_valid (out_text_valid),
  .out_text_char  (out_text_char),
  .out_char_index (out_char_index),
  .out_text_end   (out_text_end),
  .out_overflowed (out_overflowed),
  .out_run_last   (out_run_last)
);
